// ===== sv/imu_shake_gesture_detector_assert.svh =====
// Assertion macros for the shake gesture detector checker.
`ifndef IMU_SHAKE_GESTURE_DETECTOR_ASSERT_SVH
`define IMU_SHAKE_GESTURE_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset
`define ISGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset
`define ISGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/isgd_pkg.sv =====
// Types, constants and helper functions for the shake gesture detector.
package isgd_pkg;

    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned SUM_W    = 18;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned NEED_W   = 4;
    localparam int unsigned HITS_W   = 5;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned CFG_D_W  = 32;

    localparam logic [HITS_W-1:0] HIT_MAX = 5'd16;

    // Register indexes on the configuration port
    localparam logic [CFG_IX_W-1:0] CFG_GYRO_THR  = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_ACCEL_THR = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_COOLDOWN  = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_HITS_NEED = 2'd3;

    // Register values after reset
    localparam logic [SUM_W-1:0]  RST_GYRO_THR  = 18'd30000;
    localparam logic [SUM_W-1:0]  RST_ACCEL_THR = 18'd18000;
    localparam logic [TICK_W-1:0] RST_COOLDOWN  = 32'd3000;
    localparam logic [NEED_W-1:0] RST_HITS_NEED = 4'd2;

    typedef struct packed {
        logic                     gyro_ready;
        logic                     accel_ready;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [TICK_W-1:0]        now_tick;
    } t_poll;

    typedef struct packed {
        logic              trigger;
        logic [HITS_W-1:0] hits;
    } t_result;

    typedef struct packed {
        logic [SUM_W-1:0]  gyro_threshold;
        logic [SUM_W-1:0]  accel_threshold;
        logic [TICK_W-1:0] cooldown_ticks;
        logic [NEED_W-1:0] hits_needed;
    } t_cfg;

    // Magnitude of a signed axis; -32768 maps to 32768
    function automatic logic [MAG_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] neg;
        neg = -v;
        return v[AXIS_W-1] ? neg : v;
    endfunction

    // Magnitude of the difference of two signed axes
    function automatic logic [MAG_W-1:0] absdiff16(input logic signed [AXIS_W-1:0] a,
                                                   input logic signed [AXIS_W-1:0] b);
        logic signed [AXIS_W:0] d;
        logic [AXIS_W:0]        neg;
        d   = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
        neg = -d;
        return d[AXIS_W] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // Hit count increment saturating at HIT_MAX
    function automatic logic [HITS_W-1:0] sat_inc(input logic [HITS_W-1:0] h);
        return (h >= HIT_MAX) ? h : h + 5'd1;
    endfunction

endpackage

// ===== sv/isgd_if.sv =====
// Valid/ready channel interfaces for poll items and result items.
interface isgd_poll_if;
    logic              valid;
    logic              ready;
    isgd_pkg::t_poll   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isgd_result_if;
    logic              valid;
    logic              ready;
    isgd_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/isgd_cfg_regs.sv =====
// Configuration registers: thresholds, cooldown and required hit count.
module isgd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [isgd_pkg::CFG_IX_W-1:0]       i_cfg_index,
    input  logic [isgd_pkg::CFG_D_W-1:0]        i_cfg_wdata,
    output isgd_pkg::t_cfg                      o_cfg
);

    isgd_pkg::t_cfg r_cfg;

    // Register write, fields truncated to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_threshold  <= isgd_pkg::RST_GYRO_THR;
            r_cfg.accel_threshold <= isgd_pkg::RST_ACCEL_THR;
            r_cfg.cooldown_ticks  <= isgd_pkg::RST_COOLDOWN;
            r_cfg.hits_needed     <= isgd_pkg::RST_HITS_NEED;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                isgd_pkg::CFG_GYRO_THR: begin
                    r_cfg.gyro_threshold <= i_cfg_wdata[isgd_pkg::SUM_W-1:0];
                end
                isgd_pkg::CFG_ACCEL_THR: begin
                    r_cfg.accel_threshold <= i_cfg_wdata[isgd_pkg::SUM_W-1:0];
                end
                isgd_pkg::CFG_COOLDOWN: begin
                    r_cfg.cooldown_ticks <= i_cfg_wdata[isgd_pkg::TICK_W-1:0];
                end
                isgd_pkg::CFG_HITS_NEED: begin
                    r_cfg.hits_needed <= i_cfg_wdata[isgd_pkg::NEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/isgd_core.sv =====
// Per-poll evaluation: gyro and accel hit tests, hit counting, trigger and cooldown.
module isgd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  isgd_pkg::t_poll    i_poll,
    input  isgd_pkg::t_cfg     i_cfg,
    output isgd_pkg::t_result  o_result
);

    logic signed [isgd_pkg::AXIS_W-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic                               r_have_prev;
    logic [isgd_pkg::HITS_W-1:0]        r_hits;
    logic [isgd_pkg::TICK_W-1:0]        r_last_tick;
    logic                               r_ever;

    logic [isgd_pkg::SUM_W-1:0]  rate_mag_total, accel_sum;
    logic                        gyro_hit, accel_hit;
    logic [isgd_pkg::TICK_W-1:0] since_last;
    logic                        cool_ok;
    logic [isgd_pkg::HITS_W-1:0] hits_g, hits_a, n_hits;
    logic                        skip_check, check, fire;

    // Sums of magnitudes; both tests run side by side
    always_comb begin
        rate_mag_total = isgd_pkg::SUM_W'(isgd_pkg::abs16(i_poll.gyro_x))
                       + isgd_pkg::SUM_W'(isgd_pkg::abs16(i_poll.gyro_y))
                       + isgd_pkg::SUM_W'(isgd_pkg::abs16(i_poll.gyro_z));
        accel_sum = isgd_pkg::SUM_W'(isgd_pkg::absdiff16(i_poll.accel_x, r_prev_x))
                  + isgd_pkg::SUM_W'(isgd_pkg::absdiff16(i_poll.accel_y, r_prev_y))
                  + isgd_pkg::SUM_W'(isgd_pkg::absdiff16(i_poll.accel_z, r_prev_z));
        gyro_hit  = rate_mag_total > i_cfg.gyro_threshold;
        accel_hit = accel_sum > i_cfg.accel_threshold;
    end

    // Cooldown test on the wrapping tick difference
    assign since_last = i_poll.now_tick - r_last_tick;
    assign cool_ok    = !r_ever || (since_last >= i_cfg.cooldown_ticks);

    // Hit count: gyro first, then accel, then the trigger check
    always_comb begin
        hits_g = (i_poll.gyro_ready && gyro_hit) ? isgd_pkg::sat_inc(r_hits) : r_hits;
        hits_a = hits_g;
        if (i_poll.accel_ready && r_have_prev) begin
            if (accel_hit) begin
                hits_a = isgd_pkg::sat_inc(hits_g);
            end else if (hits_g != '0) begin
                hits_a = hits_g - 5'd1;
            end
        end
        // first accel sample only primes the history
        skip_check = i_poll.accel_ready && !r_have_prev;
        check      = !skip_check && (hits_a >= {1'b0, i_cfg.hits_needed});
        fire       = check && cool_ok;
        n_hits     = check ? '0 : hits_a;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_hits      <= '0;
            r_ever      <= 1'b0;
        end else if (i_step) begin
            r_hits <= n_hits;
            if (i_poll.accel_ready) begin
                r_have_prev <= 1'b1;
            end
            if (fire) begin
                r_ever <= 1'b1;
            end
        end
    end

    // Sample history and last trigger time, read only once marked valid
    always_ff @(posedge i_clk) begin
        if (i_step && i_poll.accel_ready) begin
            r_prev_x <= i_poll.accel_x;
            r_prev_y <= i_poll.accel_y;
            r_prev_z <= i_poll.accel_z;
        end
        if (i_step && fire) begin
            r_last_tick <= i_poll.now_tick;
        end
    end

    assign o_result.trigger = fire;
    assign o_result.hits    = n_hits;

endmodule

// ===== sv/imu_shake_gesture_detector.sv =====
// Shake gesture detector: takes one IMU poll per clock cycle unless the result side stalls, and
// returns one result item (trigger pulse and hit count) per poll. A poll passes an input register,
// the evaluation logic and a result register, which presents the result once the poll has been
// evaluated; the hit count and trigger history live in single registers updated once per poll,
// which sets the sustained rate at one poll per cycle while the result side keeps taking items.
module imu_shake_gesture_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    isgd_poll_if.sink                     i_poll,
    isgd_result_if.source                 o_result,
    input  logic                          i_cfg_wr_en,
    input  logic [isgd_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [isgd_pkg::CFG_D_W-1:0]  i_cfg_wdata
);

    isgd_pkg::t_cfg    cfg;
    isgd_pkg::t_poll   r_in;
    logic              r_in_vld;
    isgd_pkg::t_result core_res;
    isgd_pkg::t_result r_out;
    logic              r_out_vld;
    logic              step;

    isgd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Evaluate the held poll when the result register is free or being drained
    assign step         = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_poll.ready = !r_in_vld || step;

    isgd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_poll   (r_in),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // Valid bits of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_poll.ready) begin
                r_in_vld <= i_poll.valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_poll.ready && i_poll.valid) begin
            r_in <= i_poll.data;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

// ===== sv/isgd_checker.sv =====
// Port-level checker for the shake gesture detector, bound to the top level.
`include "imu_shake_gesture_detector_assert.svh"

module isgd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_trigger,
    input logic [isgd_pkg::HITS_W-1:0]   i_out_hits
);

    // A stalled result item holds its payload
    `ISGD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_trigger) && $stable(i_out_hits), "result item changed while stalled")

    // A trigger always clears the hit count
    `ISGD_ASSERT_NOW(a_trig_clears, i_out_valid && i_out_trigger, i_out_hits == '0, "trigger with nonzero hit count")

    // Hit count saturates
    `ISGD_ASSERT_NOW(a_hits_max, i_out_valid, i_out_hits <= isgd_pkg::HIT_MAX, "hit count above saturation")

    // No result item right after reset
    `ISGD_ASSERT_NOW(a_rst_empty, $past(!i_rst_n), !i_out_valid, "result valid right after reset")

endmodule

bind imu_shake_gesture_detector isgd_checker u_isgd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_trigger (o_result.data.trigger),
    .i_out_hits    (o_result.data.hits)
);
